>>> sv/assert_macros.svh
// assertion macros for the rpn stack calculator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RSC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define RSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RSC_ASSERT(label, clk, rst_n, prop)
`define RSC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/rsc_pkg.sv
// types, codes and helper functions of the rpn stack calculator
package rsc_pkg;
    localparam int RSC_STACK_DEPTH = 128;
    localparam int RSC_VAR_COUNT   = 52;
    localparam int RSC_FRAC_BITS   = 16;

    localparam int VAL_W  = 32;
    localparam int MODE_W = 4;
    localparam int VIDX_W = 6;
    localparam int STAT_W = 3;

    localparam int SAVE_VAR = 25;

    localparam logic [MODE_W-1:0] MD_NUM   = 4'd0;
    localparam logic [MODE_W-1:0] MD_VAR   = 4'd1;
    localparam logic [MODE_W-1:0] MD_ASG   = 4'd2;
    localparam logic [MODE_W-1:0] MD_ADD   = 4'd3;
    localparam logic [MODE_W-1:0] MD_SUB   = 4'd4;
    localparam logic [MODE_W-1:0] MD_MUL   = 4'd5;
    localparam logic [MODE_W-1:0] MD_DIV   = 4'd6;
    localparam logic [MODE_W-1:0] MD_MOD   = 4'd7;
    localparam logic [MODE_W-1:0] MD_SHOW  = 4'd8;
    localparam logic [MODE_W-1:0] MD_DUP   = 4'd9;
    localparam logic [MODE_W-1:0] MD_SWAP  = 4'd10;
    localparam logic [MODE_W-1:0] MD_CLEAR = 4'd11;
    localparam logic [MODE_W-1:0] MD_EOL   = 4'd12;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_ZDIV    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOVAR   = 3'd4;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd5;

    typedef logic signed [VAL_W-1:0] t_val;

    function automatic logic [STAT_W-1:0] f_flag(input logic [STAT_W-1:0] cur,
                                                 input logic [STAT_W-1:0] code);
        return (cur == ST_OK) ? code : cur;
    endfunction

    function automatic t_val f_sat(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] f_abs(input t_val x);
        return x[VAL_W-1] ? (32'd0 - x) : x;
    endfunction
endpackage

>>> sv/rsc_if.sv
// request and response channel interfaces
interface rsc_req_if import rsc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    t_val              number_value;
    logic [VIDX_W-1:0] var_index;

    modport source (output valid, mode, number_value, var_index, input ready);
    modport sink   (input valid, mode, number_value, var_index, output ready);
endinterface

interface rsc_rsp_if import rsc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              has_value;
    t_val              shown_value;
    logic [STAT_W-1:0] status;

    modport source (output valid, has_value, shown_value, status, input ready);
    modport sink   (input valid, has_value, shown_value, status, output ready);
endinterface

>>> sv/rsc_stack_mem.sv
// value stack memory, one write and one registered read port
module rsc_stack_mem import rsc_pkg::*; #(
    parameter int STACK_DEPTH = RSC_STACK_DEPTH,
    parameter int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_val          i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_val          o_rdata
);
    t_val mem [STACK_DEPTH];
    t_val r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/rsc_var_mem.sv
// variable store memory with per-entry valid bits, unwritten entries read zero
module rsc_var_mem import rsc_pkg::*; #(
    parameter int VAR_COUNT = RSC_VAR_COUNT,
    parameter int VW = $clog2(VAR_COUNT)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [VW-1:0] i_waddr,
    input  t_val          i_wdata,
    input  logic          i_re,
    input  logic [VW-1:0] i_raddr,
    output t_val          o_rdata
);
    t_val                 mem [VAR_COUNT];
    logic [VAR_COUNT-1:0] r_valid;
    t_val                 r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_valid[i_raddr] ? mem[i_raddr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/rsc_div.sv
// bit-serial restoring divider on magnitudes, one quotient bit per cycle
module rsc_div import rsc_pkg::*; #(
    parameter int NB = VAL_W + RSC_FRAC_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NB-1:0]    i_dividend,
    input  logic [VAL_W-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [NB-1:0]    o_quot,
    output logic [VAL_W-1:0] o_rem
);
    localparam int SW = $clog2(NB + 1);

    logic             r_busy, r_done;
    logic [SW-1:0]    r_n;
    logic [NB-1:0]    r_q;
    logic [VAL_W-1:0] r_rem, r_d;
    logic [VAL_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_q[NB-1]};
    assign w_ge    = (w_trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_n    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_n    <= '0;
            end else if (r_busy) begin
                r_n <= r_n + SW'(1);
                if (r_n == SW'(NB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[NB-2:0], w_ge};
            r_rem <= w_ge ? VAL_W'(w_trial - {1'b0, r_d}) : w_trial[VAL_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

>>> sv/rpn_stack_calculator_top.sv
// rpn stack calculator top: token sequencer around stack and variable memories
// every token passes a decode state and a finish state; stack and variable reads add states between
// swap reads both top entries, then writes them back swapped; mul registers the product first
// div and mod wait on the bit-serial divider
// one token in flight at a time; a finished response waits in the output register
// synchronous reset clears stack count, line state and variable valid bits
`include "assert_macros.svh"
module rpn_stack_calculator_top import rsc_pkg::*; #(
    parameter int STACK_DEPTH = RSC_STACK_DEPTH,
    parameter int VAR_COUNT   = RSC_VAR_COUNT,
    parameter int FRAC_BITS   = RSC_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rsc_req_if.sink   i_req,
    rsc_rsp_if.source o_rsp
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int VW = $clog2(VAR_COUNT);
    localparam int NB = VAL_W + FRAC_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_VPUSH = 4'd2;
    localparam logic [3:0] S_ASG   = 4'd3;
    localparam logic [3:0] S_POPB  = 4'd4;
    localparam logic [3:0] S_POPA  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_SHOW  = 4'd8;
    localparam logic [3:0] S_DUP   = 4'd9;
    localparam logic [3:0] S_SW1   = 4'd10;
    localparam logic [3:0] S_SW2   = 4'd11;
    localparam logic [3:0] S_SW3   = 4'd12;
    localparam logic [3:0] S_EOL   = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;

    logic [3:0]        r_state, n_state;
    logic [MODE_W-1:0] r_mode, n_mode;
    t_val              r_num, n_num;
    logic [VIDX_W-1:0] r_vidx, n_vidx;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [VW-1:0]     r_rvar, n_rvar;
    logic              r_seen, n_seen;
    logic [1:0]        r_slot, n_slot;
    logic [1:0]        r_pos, n_pos;
    logic              r_asg, n_asg;
    logic [STAT_W-1:0] r_stat, n_stat;
    logic              r_has, n_has;
    t_val              r_shown, n_shown;
    logic              r_rd_ok, n_rd_ok;
    t_val              r_a, n_a;
    t_val              r_b, n_b;
    logic signed [63:0] r_prod, n_prod;
    logic              r_ov;
    logic              r_o_has;
    t_val              r_o_shown;
    logic [STAT_W-1:0] r_o_stat;

    logic          s_we, s_re;
    logic [AW-1:0] s_waddr, s_raddr;
    t_val          s_wdata, s_rdata;
    logic          v_we, v_re;
    logic [VW-1:0] v_waddr, v_raddr;
    t_val          v_wdata, v_rdata;

    logic             w_div_start, w_div_busy, w_div_done;
    logic [NB-1:0]    w_div_dvd, w_quot;
    logic [VAL_W-1:0] w_div_dvs, w_rem;

    logic w_load_out;

    rsc_stack_mem #(.STACK_DEPTH(STACK_DEPTH), .AW(AW)) u_stack (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata(s_wdata),
        .i_re   (s_re),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    rsc_var_mem #(.VAR_COUNT(VAR_COUNT), .VW(VW)) u_vars (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (v_we),
        .i_waddr(v_waddr),
        .i_wdata(v_wdata),
        .i_re   (v_re),
        .i_raddr(v_raddr),
        .o_rdata(v_rdata)
    );

    rsc_div #(.NB(NB)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(w_div_dvd),
        .i_divisor (w_div_dvs),
        .o_busy    (w_div_busy),
        .o_done    (w_div_done),
        .o_quot    (w_quot),
        .o_rem     (w_rem)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_load_out  = (r_state == S_FIN) && (!r_ov || o_rsp.ready);

    always_comb begin
        logic [CW-1:0]    c;
        t_val             a, b, res, mval;
        logic [VAL_W-1:0] mag;
        logic             p_en;
        t_val             p_val;

        n_state = r_state;
        n_mode  = r_mode;
        n_num   = r_num;
        n_vidx  = r_vidx;
        n_cnt   = r_cnt;
        n_rvar  = r_rvar;
        n_seen  = r_seen;
        n_slot  = r_slot;
        n_pos   = r_pos;
        n_asg   = r_asg;
        n_stat  = r_stat;
        n_has   = r_has;
        n_shown = r_shown;
        n_rd_ok = r_rd_ok;
        n_a     = r_a;
        n_b     = r_b;
        n_prod  = r_prod;

        s_we    = 1'b0;
        s_waddr = '0;
        s_wdata = '0;
        s_re    = 1'b0;
        s_raddr = AW'(r_cnt - CW'(1));
        v_we    = 1'b0;
        v_waddr = r_rvar;
        v_wdata = '0;
        v_re    = 1'b0;
        v_raddr = r_vidx[VW-1:0];

        w_div_start = 1'b0;
        w_div_dvd   = '0;
        w_div_dvs   = '0;

        c     = r_cnt;
        a     = '0;
        b     = '0;
        res   = '0;
        mval  = '0;
        mag   = '0;
        p_en  = 1'b0;
        p_val = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_mode  = i_req.mode;
                    n_num   = i_req.number_value;
                    n_vidx  = i_req.var_index;
                    n_stat  = ST_OK;
                    n_has   = 1'b0;
                    n_shown = '0;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_pos   = (r_pos < 2'd2) ? r_pos + 2'd1 : 2'd2;
                n_state = S_FIN;
                unique case (r_mode)
                    MD_NUM: begin
                        p_en  = 1'b1;
                        p_val = r_num;
                    end
                    MD_VAR: begin
                        if ({1'b0, r_vidx} >= 7'(VAR_COUNT)) begin
                            n_stat = f_flag(n_stat, ST_NOVAR);
                        end else begin
                            n_rvar = r_vidx[VW-1:0];
                            n_seen = 1'b1;
                            if (r_pos == 2'd0) begin
                                n_slot = 2'd1;
                            end else if (r_pos == 2'd1) begin
                                n_slot = 2'd2;
                            end
                            v_re    = 1'b1;
                            n_state = S_VPUSH;
                        end
                    end
                    MD_ASG: begin
                        if (!r_seen) begin
                            n_stat = f_flag(n_stat, ST_NOVAR);
                        end else begin
                            if (r_slot == 2'd2) begin
                                if (c != '0) begin
                                    c = c - CW'(1);
                                end else begin
                                    n_stat = f_flag(n_stat, ST_EMPTY);
                                end
                            end
                            if (c != '0) begin
                                s_re    = 1'b1;
                                s_raddr = AW'(c - CW'(1));
                                n_rd_ok = 1'b1;
                                c       = c - CW'(1);
                            end else begin
                                n_rd_ok = 1'b0;
                                n_stat  = f_flag(n_stat, ST_EMPTY);
                            end
                            n_cnt   = c;
                            n_state = S_ASG;
                        end
                    end
                    MD_ADD, MD_SUB, MD_MUL, MD_DIV, MD_MOD: begin
                        if (r_cnt != '0) begin
                            s_re    = 1'b1;
                            n_rd_ok = 1'b1;
                            n_cnt   = r_cnt - CW'(1);
                        end else begin
                            n_rd_ok = 1'b0;
                            n_stat  = f_flag(n_stat, ST_EMPTY);
                        end
                        n_state = S_POPB;
                    end
                    MD_SHOW: begin
                        if (r_cnt != '0) begin
                            s_re    = 1'b1;
                            n_state = S_SHOW;
                        end else begin
                            n_stat = f_flag(n_stat, ST_EMPTY);
                        end
                    end
                    MD_DUP: begin
                        if (r_cnt != '0) begin
                            s_re    = 1'b1;
                            n_state = S_DUP;
                        end else begin
                            n_stat = f_flag(n_stat, ST_EMPTY);
                        end
                    end
                    MD_SWAP: begin
                        if (r_cnt >= CW'(2)) begin
                            s_re    = 1'b1;
                            n_state = S_SW1;
                        end else begin
                            n_stat = f_flag(n_stat, ST_EMPTY);
                        end
                    end
                    MD_CLEAR: begin
                        n_cnt = '0;
                    end
                    MD_EOL: begin
                        if (!r_asg) begin
                            if (r_cnt != '0) begin
                                s_re    = 1'b1;
                                n_cnt   = r_cnt - CW'(1);
                                n_state = S_EOL;
                            end else begin
                                n_stat = f_flag(n_stat, ST_EMPTY);
                            end
                        end
                        n_asg  = 1'b0;
                        n_rvar = '0;
                        n_seen = 1'b0;
                        n_slot = 2'd0;
                        n_pos  = 2'd0;
                    end
                    default: begin
                        n_stat = f_flag(n_stat, ST_UNKNOWN);
                    end
                endcase
            end
            S_VPUSH: begin
                p_en    = 1'b1;
                p_val   = v_rdata;
                n_state = S_FIN;
            end
            S_ASG: begin
                v_we    = 1'b1;
                v_waddr = r_rvar;
                v_wdata = r_rd_ok ? s_rdata : '0;
                if (r_slot == 2'd1) begin
                    if (r_cnt != '0) begin
                        n_cnt = r_cnt - CW'(1);
                    end else begin
                        n_stat = f_flag(n_stat, ST_EMPTY);
                    end
                end
                n_asg   = 1'b1;
                n_state = S_FIN;
            end
            S_POPB: begin
                b   = r_rd_ok ? s_rdata : '0;
                n_b = b;
                mag = f_abs(b);
                if ((r_mode == MD_DIV && b == '0) ||
                    (r_mode == MD_MOD && mag[VAL_W-1:FRAC_BITS] == '0)) begin
                    n_stat  = f_flag(n_stat, ST_ZDIV);
                    n_state = S_FIN;
                end else begin
                    if (r_cnt != '0) begin
                        s_re    = 1'b1;
                        n_rd_ok = 1'b1;
                        n_cnt   = r_cnt - CW'(1);
                    end else begin
                        n_rd_ok = 1'b0;
                        n_stat  = f_flag(n_stat, ST_EMPTY);
                    end
                    n_state = S_POPA;
                end
            end
            S_POPA: begin
                a   = r_rd_ok ? s_rdata : '0;
                b   = r_b;
                n_a = a;
                case (r_mode)
                    MD_ADD: begin
                        p_en    = 1'b1;
                        p_val   = f_sat(64'(a) + 64'(b));
                        n_state = S_FIN;
                    end
                    MD_SUB: begin
                        p_en    = 1'b1;
                        p_val   = f_sat(64'(a) - 64'(b));
                        n_state = S_FIN;
                    end
                    MD_MUL: begin
                        n_prod  = a * b;
                        n_state = S_MUL;
                    end
                    MD_DIV: begin
                        w_div_start = 1'b1;
                        w_div_dvd   = NB'(f_abs(a)) << FRAC_BITS;
                        w_div_dvs   = f_abs(b);
                        n_state     = S_DIV;
                    end
                    default: begin
                        w_div_start = 1'b1;
                        w_div_dvd   = NB'(f_abs(a) >> FRAC_BITS);
                        w_div_dvs   = f_abs(b) >> FRAC_BITS;
                        n_state     = S_DIV;
                    end
                endcase
            end
            S_MUL: begin
                p_en    = 1'b1;
                p_val   = f_sat(r_prod >>> FRAC_BITS);
                n_state = S_FIN;
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (r_mode == MD_DIV) begin
                        if (r_a[VAL_W-1] ^ r_b[VAL_W-1]) begin
                            res = (w_quot > NB'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                                        : 32'd0 - w_quot[VAL_W-1:0];
                        end else begin
                            res = (w_quot > NB'(32'h7fff_ffff)) ? 32'h7fff_ffff
                                                                 : w_quot[VAL_W-1:0];
                        end
                    end else begin
                        mval = VAL_W'(w_rem << FRAC_BITS);
                        res  = r_a[VAL_W-1] ? 32'd0 - mval : mval;
                    end
                    p_en    = 1'b1;
                    p_val   = res;
                    n_state = S_FIN;
                end
            end
            S_SHOW: begin
                n_has   = 1'b1;
                n_shown = s_rdata;
                n_state = S_FIN;
            end
            S_DUP: begin
                p_en    = 1'b1;
                p_val   = s_rdata;
                n_state = S_FIN;
            end
            S_SW1: begin
                n_a     = s_rdata;
                s_re    = 1'b1;
                s_raddr = AW'(r_cnt - CW'(2));
                n_state = S_SW2;
            end
            S_SW2: begin
                s_we    = 1'b1;
                s_waddr = AW'(r_cnt - CW'(1));
                s_wdata = s_rdata;
                n_state = S_SW3;
            end
            S_SW3: begin
                s_we    = 1'b1;
                s_waddr = AW'(r_cnt - CW'(2));
                s_wdata = r_a;
                n_state = S_FIN;
            end
            S_EOL: begin
                n_has   = 1'b1;
                n_shown = s_rdata;
                v_we    = 1'b1;
                v_waddr = VW'(SAVE_VAR);
                v_wdata = s_rdata;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ov || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (p_en) begin
            if (r_cnt < CW'(STACK_DEPTH)) begin
                s_we    = 1'b1;
                s_waddr = AW'(r_cnt);
                s_wdata = p_val;
                n_cnt   = r_cnt + CW'(1);
            end else begin
                n_stat = f_flag(n_stat, ST_FULL);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_rvar  <= '0;
            r_seen  <= 1'b0;
            r_slot  <= 2'd0;
            r_pos   <= 2'd0;
            r_asg   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rvar  <= n_rvar;
            r_seen  <= n_seen;
            r_slot  <= n_slot;
            r_pos   <= n_pos;
            r_asg   <= n_asg;
            if (w_load_out) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_num   <= n_num;
        r_vidx  <= n_vidx;
        r_stat  <= n_stat;
        r_has   <= n_has;
        r_shown <= n_shown;
        r_rd_ok <= n_rd_ok;
        r_a     <= n_a;
        r_b     <= n_b;
        r_prod  <= n_prod;
        if (w_load_out) begin
            r_o_has   <= r_has;
            r_o_shown <= r_shown;
            r_o_stat  <= r_stat;
        end
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.has_value   = r_o_has;
    assign o_rsp.shown_value = r_o_shown;
    assign o_rsp.status      = r_o_stat;

    `RSC_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(STACK_DEPTH))
    `RSC_ASSERT_NEXT(a_accept_dec, i_clk, i_rst_n, i_req.valid && i_req.ready, r_state == S_DEC)
    `RSC_ASSERT_IMPL(a_div_start, i_clk, i_rst_n, w_div_start, !w_div_busy)
    `RSC_ASSERT_IMPL(a_no_value, i_clk, i_rst_n, o_rsp.valid && !o_rsp.has_value, o_rsp.shown_value == '0)
endmodule

>>> bench/tb_rsc_if.sv
// the bench shares the request and response channel interfaces of sv/rsc_if.sv

>>> bench/tb_top.sv
// token-level bench for the rpn stack calculator: directed lines, then random traffic
module tb_top;
    import rsc_pkg::*;

    localparam int WDOG_LIMIT = 20000;
    localparam logic [MODE_W-1:0] MD_UNK = 4'd13;

    typedef struct packed {
        logic              has;
        t_val              val;
        logic [STAT_W-1:0] st;
    } calc_resp_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rsc_req_if req ();
    rsc_rsp_if rsp ();

    rpn_stack_calculator_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req.sink),
        .o_rsp   (rsp.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    t_val              stk [RSC_STACK_DEPTH];
    int                depth;
    t_val              vars [RSC_VAR_COUNT];
    int                cur_var;
    bit                var_seen;
    int                var_slot;
    int                tok_pos;
    bit                line_asg;
    logic [STAT_W-1:0] st_acc;

    calc_resp_t pending_resp [$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  timed_out = 0;
    bit  burst_on = 1;
    int  burst_left = 0;

    function automatic void raise(logic [STAT_W-1:0] s);
        if (st_acc == ST_OK) st_acc = s;
    endfunction

    function automatic void stk_push(t_val v);
        if (depth < RSC_STACK_DEPTH) begin
            stk[depth] = v;
            depth++;
        end else begin
            raise(ST_FULL);
        end
    endfunction

    function automatic t_val stk_pop();
        if (depth > 0) begin
            depth--;
            return stk[depth];
        end
        raise(ST_EMPTY);
        return '0;
    endfunction

    function automatic t_val clamp32(logic signed [63:0] v);
        if (v > 64'sh7fffffff) return 32'h7fffffff;
        if (v < -64'sh80000000) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic longint trunc_int(t_val x);
        longint v;
        v = x;
        if (v >= 0) return v >>> RSC_FRAC_BITS;
        return -((-v) >>> RSC_FRAC_BITS);
    endfunction

    function automatic calc_resp_t run_token(logic [MODE_W-1:0] md, t_val num,
                                              logic [VIDX_W-1:0] vi);
        calc_resp_t r;
        int pos;
        t_val a, b, tmp;
        longint p, ai, bi;
        r = '0;
        st_acc = ST_OK;
        pos = tok_pos;
        tok_pos = (pos < 2) ? pos + 1 : 2;
        case (md)
            MD_NUM: stk_push(num);
            MD_VAR: begin
                if (vi >= RSC_VAR_COUNT) begin
                    raise(ST_NOVAR);
                end else begin
                    cur_var = vi;
                    var_seen = 1;
                    stk_push(vars[vi]);
                    if (pos == 0) var_slot = 1;
                    else if (pos == 1) var_slot = 2;
                end
            end
            MD_ASG: begin
                if (!var_seen) begin
                    raise(ST_NOVAR);
                end else begin
                    if (var_slot == 2) void'(stk_pop());
                    a = stk_pop();
                    vars[cur_var] = a;
                    if (var_slot == 1) void'(stk_pop());
                    line_asg = 1;
                end
            end
            MD_ADD, MD_SUB: begin
                b = stk_pop();
                a = stk_pop();
                p = (md == MD_ADD) ? longint'(a) + longint'(b) : longint'(a) - longint'(b);
                stk_push(clamp32(p));
            end
            MD_MUL: begin
                b = stk_pop();
                a = stk_pop();
                p = longint'(a) * longint'(b);
                stk_push(clamp32(p >>> RSC_FRAC_BITS));
            end
            MD_DIV: begin
                b = stk_pop();
                if (b == 0) begin
                    raise(ST_ZDIV);
                end else begin
                    a = stk_pop();
                    p = (longint'(a) * (longint'(1) << RSC_FRAC_BITS)) / longint'(b);
                    stk_push(clamp32(p));
                end
            end
            MD_MOD: begin
                b = stk_pop();
                bi = trunc_int(b);
                if (bi == 0) begin
                    raise(ST_ZDIV);
                end else begin
                    a = stk_pop();
                    ai = trunc_int(a);
                    stk_push(clamp32((ai % bi) * (longint'(1) << RSC_FRAC_BITS)));
                end
            end
            MD_SHOW: begin
                if (depth > 0) begin
                    r.has = 1;
                    r.val = stk[depth-1];
                end else begin
                    raise(ST_EMPTY);
                end
            end
            MD_DUP: begin
                if (depth == 0) raise(ST_EMPTY);
                else stk_push(stk[depth-1]);
            end
            MD_SWAP: begin
                if (depth < 2) begin
                    raise(ST_EMPTY);
                end else begin
                    tmp = stk[depth-1];
                    stk[depth-1] = stk[depth-2];
                    stk[depth-2] = tmp;
                end
            end
            MD_CLEAR: depth = 0;
            MD_EOL: begin
                if (!line_asg) begin
                    if (depth > 0) begin
                        r.val = stk_pop();
                        r.has = 1;
                        vars[SAVE_VAR] = r.val;
                    end else begin
                        raise(ST_EMPTY);
                    end
                end
                line_asg = 0;
                cur_var = 0;
                var_seen = 0;
                var_slot = 0;
                tok_pos = 0;
            end
            default: raise(ST_UNKNOWN);
        endcase
        r.st = st_acc;
        return r;
    endfunction

    // send one request, with bursty gaps
    task automatic send_token(logic [MODE_W-1:0] md, t_val num, logic [VIDX_W-1:0] vi);
        while (!burst_on) begin
            @(posedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                burst_on = 1;
                burst_left = $urandom_range(1, 20);
            end
        end
        req.valid <= 1'b1;
        req.mode <= md;
        req.number_value <= num;
        req.var_index <= vi;
        do @(posedge i_clk); while (!req.ready);
        pending_resp.push_back(run_token(md, num, vi));
        if (burst_left > 0) burst_left--;
        if (burst_left == 0 && $urandom_range(0, 1)) begin
            burst_on = 0;
            req.valid <= 1'b0;
        end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
        end
    endtask

    task automatic drain();
        @(posedge i_clk);
        req.valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_val rand_val();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 20) << RSC_FRAC_BITS;
            3: return -($urandom_range(0, 20) << RSC_FRAC_BITS);
            default: return $urandom;
        endcase
    endfunction

    // response check
    always @(posedge i_clk) begin
        calc_resp_t e;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (pending_resp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response");
            end else begin
                e = pending_resp.pop_front();
                if (rsp.has_value !== e.has || rsp.shown_value !== e.val
                        || rsp.status !== e.st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp has=%0b val=%h st=%0d got has=%0b val=%h st=%0d",
                                 e.has, e.val, e.st, rsp.has_value, rsp.shown_value,
                                 rsp.status);
                end
            end
        end
    end

    // receiver stall pattern
    int stall_ph = 0;
    always @(posedge i_clk) begin
        stall_ph <= stall_ph + 1;
        if (stall_ph[9:8] == 2'd0) rsp.ready <= 1'b1;
        else rsp.ready <= ($urandom_range(0, 3) != 0) && (stall_ph[2:0] != 3'd5);
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT && !timed_out) begin
            timed_out <= 1;
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic test_arith_extremes();
        send_token(MD_NUM, 32'h7fffffff, 0);
        send_token(MD_NUM, 32'h7fffffff, 0);
        send_token(MD_ADD, 0, 0);
        send_token(MD_NUM, 32'h80000000, 0);
        send_token(MD_MUL, 0, 0);
        send_token(MD_NUM, 32'h00030000, 0);
        send_token(MD_SUB, 0, 0);
        send_token(MD_NUM, 32'h00008000, 0);
        send_token(MD_DIV, 0, 0);
        send_token(MD_NUM, 32'hfffd0000, 0);
        send_token(MD_MOD, 0, 0);
        send_token(MD_SHOW, 0, 0);
        send_token(MD_EOL, 0, 0);
    endtask

    task automatic test_errors();
        send_token(MD_EOL, 0, 0);
        send_token(MD_SHOW, 0, 0);
        send_token(MD_DUP, 0, 0);
        send_token(MD_NUM, 32'h00010000, 0);
        send_token(MD_SWAP, 0, 0);
        send_token(MD_NUM, 0, 0);
        send_token(MD_DIV, 0, 0);
        send_token(MD_NUM, 32'h00008000, 0);
        send_token(MD_MOD, 0, 0);
        send_token(MD_ASG, 0, 0);
        send_token(MD_VAR, 6'd63, 0);
        send_token(4'd15, 0, 0);
        send_token(MD_UNK, 0, 0);
        send_token(MD_ADD, 0, 0);
        send_token(MD_CLEAR, 0, 0);
        send_token(MD_ADD, 0, 0);
        send_token(MD_CLEAR, 0, 0);
        send_token(MD_EOL, 0, 0);
    endtask

    task automatic test_assign_lines();
        send_token(MD_VAR, 6'd51, 0);
        send_token(MD_NUM, 32'h00050000, 0);
        send_token(MD_ASG, 0, 0);
        send_token(MD_EOL, 0, 0);
        send_token(MD_NUM, 32'h00020000, 0);
        send_token(MD_VAR, 6'd0, 0);
        send_token(MD_ASG, 0, 0);
        send_token(MD_EOL, 0, 0);
        send_token(MD_VAR, 6'd51, 0);
        send_token(MD_VAR, 6'd0, 0);
        send_token(MD_ADD, 0, 0);
        send_token(MD_EOL, 0, 0);
        send_token(MD_VAR, 6'd25, 0);
        send_token(MD_EOL, 0, 0);
    endtask

    task automatic test_stack_full();
        for (int i = 0; i < RSC_STACK_DEPTH; i++) send_token(MD_NUM, $urandom, 0);
        send_token(MD_NUM, 32'h1, 0);
        send_token(MD_DUP, 0, 0);
        send_token(MD_SWAP, 0, 0);
        send_token(MD_CLEAR, 0, 0);
        send_token(MD_EOL, 0, 0);
    endtask

    task automatic test_random_lines(int n);
        int sent;
        int k;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) < 7) begin
                // well-formed line, optional assignment
                k = $urandom_range(0, 2);
                if (k == 1) begin
                    send_token(MD_VAR, VIDX_W'($urandom_range(0, 51)), 0);
                    sent++;
                end else if (k == 2) begin
                    send_token(MD_NUM, rand_val(), 0);
                    send_token(MD_VAR, VIDX_W'($urandom_range(0, 51)), 0);
                    sent += 2;
                end
                repeat ($urandom_range(1, 6)) begin
                    if (depth < 2 || $urandom_range(0, 1)) begin
                        if ($urandom_range(0, 2) == 0)
                            send_token(MD_VAR, VIDX_W'($urandom_range(0, 51)), 0);
                        else
                            send_token(MD_NUM, rand_val(), 0);
                    end else begin
                        send_token(MD_ADD + MODE_W'($urandom_range(0, 4)), 0, 0);
                    end
                    sent++;
                end
                if ($urandom_range(0, 2) == 0) begin
                    send_token(MD_SHOW + MODE_W'($urandom_range(0, 2)), 0, 0);
                    sent++;
                end
                if (k != 0 && $urandom_range(0, 1)) begin
                    send_token(MD_ASG, 0, 0);
                    sent++;
                end
                send_token(MD_EOL, 0, 0);
                sent++;
            end else begin
                send_token(MODE_W'($urandom_range(0, 15)), $urandom,
                           VIDX_W'($urandom_range(0, 63)));
                sent++;
            end
            if (depth > 100) begin
                send_token(MD_CLEAR, 0, 0);
                sent++;
            end
        end
    endtask

    initial begin
        req.valid = 1'b0;
        req.mode = '0;
        req.number_value = '0;
        req.var_index = '0;
        rsp.ready = 1'b0;
        depth = 0;
        cur_var = 0;
        var_seen = 0;
        var_slot = 0;
        tok_pos = 0;
        line_asg = 0;
        foreach (vars[i]) vars[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_arith_extremes();
        test_errors();
        test_assign_lines();
        test_stack_full();
        test_random_lines(870);
        drain();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending_resp.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
